FILE: hw/rtl/ppso_pkg.sv
package ppso_pkg;

  localparam int DEF_HISTORY_DEPTH = 5;
  localparam int DEF_INTERVAL_BITS = 16;

  localparam int PPK_W = 24;
  localparam int MIN_W = 16;
  localparam int ODO_W = 32;
  localparam int SPEED_W = 8;
  localparam int TRIES_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_PPK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MILEAGE_PRESET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_FILTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE = 3'd5;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [1:0] TM_NORMAL = 2'd0;
  localparam logic [1:0] TM_DIV2 = 2'd1;

  localparam logic [PPK_W-1:0] PPK_RESET = 24'd7200;
  localparam logic [MIN_W-1:0] MIN_RESET = 16'd39;

  localparam logic [27:0] SPEED_NUM2 = 28'd144000000;
  localparam logic [SPEED_W-1:0] JUMP_LIMIT = 8'd50;
  localparam logic [TRIES_W-1:0] JUMP_TRIES = 7'd100;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;
  localparam int ODO_SCALE = 100;
  localparam int ODO_RATIO = 50;

endpackage

FILE: hw/rtl/ppso_div.sv
module ppso_div #(
  parameter int W = 42
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {rem, q[W-1]};
  assign trial = shifted - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= num;
      d <= den;
    end else if (busy) begin
      rem <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
      q <= {q[W-2:0], ~trial[W]};
    end
  end

endmodule

FILE: hw/rtl/pulse_period_speed_odometer.sv
// Speedometer and odometer fed by speed-sensor pulse beats. Each input beat is a pulse
// (tuser low) carrying the interval since the previous pulse in 50 us ticks, or a timeout
// (tuser high). Every input beat gives exactly one output beat with the speed in km/h, the
// total distance in 0.01 km and the test pin level. Speed is 72000000/(interval*pulses_per_km)
// rounded half up and held at 255; distance is pending*100/pulses_per_km once pending pulses
// exceed pulses_per_km/50. Timeouts and test-mode beats go straight from S_IDLE to S_DONE;
// glitch or first pulses pass S_PULSE on the way. A full pulse runs the distance,
// trimmed-mean and speed divisions through one restoring divider, DIV_W being
// max(39, INTERVAL_BITS+26) bits wide, that retires one quotient bit per cycle and is shared
// by all three; without averaging the history sweep and the mean division drop out, without
// a distance update the distance division drops out.
// The input is not ready while a pulse is being worked on; the output beat sits in its own
// register so the next input can be taken while it waits. Configuration writes are always
// ready and must only be issued while no beat is in flight.
module pulse_period_speed_odometer #(
  parameter int HISTORY_DEPTH = ppso_pkg::DEF_HISTORY_DEPTH,
  parameter int INTERVAL_BITS = ppso_pkg::DEF_INTERVAL_BITS,
  localparam int IN_W = ((INTERVAL_BITS + 1 + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [IN_W-1:0]                    s_tdata,   // interval_ticks, ignition_on
  input  logic                               s_tuser,   // operation
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ppso_pkg::OUT_W-1:0]         m_tdata,   // instant_speed, total_mileage, test_output
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppso_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IB = INTERVAL_BITS;
  localparam int HD = HISTORY_DEPTH;
  localparam int DIV_W = (IB + 26 > 39) ? IB + 26 : 39;
  localparam int SUM_W = IB + $clog2(HD);
  localparam int IDX_W = $clog2(HD);
  localparam int CMP_W = (IB > ppso_pkg::MIN_W) ? IB : ppso_pkg::MIN_W;
  localparam int PROD_W = IB + ppso_pkg::PPK_W;
  localparam int ODO_CMP_W = ppso_pkg::ODO_W + 6;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PULSE  = 4'd1;
  localparam logic [3:0] S_ODOCHK = 4'd2;
  localparam logic [3:0] S_ODO    = 4'd3;
  localparam logic [3:0] S_BASIS  = 4'd4;
  localparam logic [3:0] S_SWEEP  = 4'd5;
  localparam logic [3:0] S_TRIM   = 4'd6;
  localparam logic [3:0] S_MEAN   = 4'd7;
  localparam logic [3:0] S_CHECK  = 4'd8;
  localparam logic [3:0] S_SPDST  = 4'd9;
  localparam logic [3:0] S_SDIV   = 4'd10;
  localparam logic [3:0] S_JUMP   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state;

  logic [ppso_pkg::PPK_W-1:0] ppk;
  logic [ppso_pkg::MIN_W-1:0] min_int;
  logic                       avg_en;
  logic                       jump_en;
  logic [1:0]                 tm;

  logic [1:0]                     pst;
  logic [ppso_pkg::ODO_W-1:0]     pending;
  logic [ppso_pkg::ODO_W-1:0]     odometer;
  logic [ppso_pkg::SPEED_W-1:0]   speed;
  logic [ppso_pkg::TRIES_W-1:0]   tries;
  logic [IB-1:0]                  hist [HD];
  logic [IDX_W-1:0]               slot;
  logic                           toggle;

  logic [IB-1:0]                  t_r;
  logic                           ign_r;
  logic [IB-1:0]                  basis;
  logic [IDX_W-1:0]               idx;
  logic [SUM_W-1:0]               sum;
  logic [IB-1:0]                  lo;
  logic [IB-1:0]                  hi;
  logic [PROD_W-1:0]              den_r;
  logic [ppso_pkg::SPEED_W-1:0]   s_r;

  logic                           div_start;
  logic [DIV_W-1:0]               div_num;
  logic [DIV_W-1:0]               div_den;
  logic                           div_done;
  logic [DIV_W-1:0]               div_quo;

  logic                           odo_go;
  logic [IDX_W:0]                 slot_inc;
  logic [IDX_W-1:0]               slot_next;
  logic [IB-1:0]                  h;
  logic [ppso_pkg::SPEED_W-1:0]   s_sat;
  logic                           out_free;

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;

  assign odo_go = ign_r && (ppk != '0) &&
                  (ODO_CMP_W'(pending) * ODO_CMP_W'(ppso_pkg::ODO_RATIO) > ODO_CMP_W'(ppk));

  assign slot_inc = {1'b0, slot} + 1'b1;
  assign slot_next = (slot_inc >= (IDX_W + 1)'(HD)) ? '0 : slot_inc[IDX_W-1:0];
  assign h = hist[idx];
  assign s_sat = (div_quo[DIV_W-1:ppso_pkg::SPEED_W] != '0) ? ppso_pkg::SPEED_MAX
                                                             : div_quo[ppso_pkg::SPEED_W-1:0];

  always_comb begin
    div_start = 1'b0;
    div_num = DIV_W'(ppso_pkg::SPEED_NUM2) + DIV_W'(den_r);
    div_den = DIV_W'({den_r, 1'b0});
    case (state)
      S_ODOCHK: begin
        div_start = odo_go;
        div_num = DIV_W'(pending) * DIV_W'(ppso_pkg::ODO_SCALE);
        div_den = DIV_W'(ppk);
      end
      S_TRIM: begin
        div_start = 1'b1;
        div_num = DIV_W'(sum - SUM_W'(lo) - SUM_W'(hi));
        div_den = DIV_W'(HD - 2);
      end
      S_SPDST: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ppso_div #(
    .W(DIV_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ppk <= ppso_pkg::PPK_RESET;
      min_int <= ppso_pkg::MIN_RESET;
      avg_en <= 1'b0;
      jump_en <= 1'b0;
      tm <= ppso_pkg::TM_NORMAL;
      pst <= '0;
      pending <= '0;
      odometer <= '0;
      speed <= '0;
      tries <= '0;
      slot <= '0;
      toggle <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < HD; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppso_pkg::REG_PPK: ppk <= cfg_data[ppso_pkg::PPK_W-1:0];
          ppso_pkg::REG_MIN_INTERVAL: min_int <= cfg_data[ppso_pkg::MIN_W-1:0];
          ppso_pkg::REG_MILEAGE_PRESET: odometer <= cfg_data[ppso_pkg::ODO_W-1:0];
          ppso_pkg::REG_AVERAGING: avg_en <= cfg_data[0];
          ppso_pkg::REG_JUMP_FILTER: jump_en <= cfg_data[0];
          ppso_pkg::REG_TEST_MODE: tm <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            t_r <= s_tdata[IB-1:0];
            ign_r <= s_tdata[IB];
            state <= S_DONE;
            if (s_tuser == ppso_pkg::OP_TIMEOUT) begin
              pst <= '0;
              speed <= '0;
              for (int i = 0; i < HD; i++) begin
                hist[i] <= '0;
              end
            end else if (tm == ppso_pkg::TM_DIV2) begin
              toggle <= ~toggle;
            end else if (tm == ppso_pkg::TM_NORMAL) begin
              state <= S_PULSE;
            end
          end
        end
        S_PULSE: begin
          if (pst != 2'd2) begin
            pst <= pst + 1'b1;
          end
          if (pst == '0) begin
            pending <= pending + 1'b1;
            state <= S_DONE;
          end else if (CMP_W'(t_r) < CMP_W'(min_int)) begin
            state <= S_DONE;
          end else begin
            pending <= pending + 1'b1;
            state <= S_ODOCHK;
          end
        end
        S_ODOCHK: begin
          state <= odo_go ? S_ODO : S_BASIS;
        end
        S_ODO: begin
          if (div_done) begin
            odometer <= odometer + div_quo[ppso_pkg::ODO_W-1:0];
            pending <= '0;
            state <= S_BASIS;
          end
        end
        S_BASIS: begin
          if (!avg_en) begin
            hist[0] <= t_r;
            basis <= t_r;
            state <= S_CHECK;
          end else begin
            slot <= slot_next;
            hist[slot_next] <= t_r;
            idx <= '0;
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (idx == '0) begin
            sum <= SUM_W'(h);
            lo <= h;
            hi <= h;
          end else begin
            sum <= sum + SUM_W'(h);
            if (h < lo) begin
              lo <= h;
            end
            if (h > hi) begin
              hi <= h;
            end
          end
          idx <= idx + 1'b1;
          if (idx == IDX_W'(HD - 1)) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          state <= S_MEAN;
        end
        S_MEAN: begin
          if (div_done) begin
            basis <= div_quo[IB-1:0];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (basis == '0) begin
            state <= S_DONE;
          end else if (!ign_r) begin
            speed <= '0;
            state <= S_DONE;
          end else if (ppk == '0) begin
            s_r <= ppso_pkg::SPEED_MAX;
            state <= S_JUMP;
          end else begin
            den_r <= PROD_W'(basis) * PROD_W'(ppk);
            state <= S_SPDST;
          end
        end
        S_SPDST: begin
          state <= S_SDIV;
        end
        S_SDIV: begin
          if (div_done) begin
            s_r <= s_sat;
            state <= S_JUMP;
          end
        end
        S_JUMP: begin
          if (jump_en && s_r > speed) begin
            if (s_r - speed >= ppso_pkg::JUMP_LIMIT) begin
              if (tries + 1'b1 >= ppso_pkg::JUMP_TRIES) begin
                tries <= '0;
                speed <= s_r;
              end else begin
                tries <= tries + 1'b1;
              end
            end else begin
              tries <= '0;
              speed <= s_r;
            end
          end else begin
            speed <= s_r;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= ppso_pkg::OUT_W'({(tm == ppso_pkg::TM_DIV2) && !toggle,
                                         odometer, speed});
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ppso_chk.sv
module ppso_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [ppso_pkg::OUT_W-1:0] m_tdata
);

  // no result left over from before reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // a new result always returns the sequencer to idle
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while still busy");

endmodule

bind pulse_period_speed_odometer ppso_chk u_ppso_chk (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

FILE: tb/sv/tb_top.sv
module tb_top;

  localparam int IN_W = ((ppso_pkg::DEF_INTERVAL_BITS + 1 + 7) / 8) * 8;
  localparam int HIST_N = ppso_pkg::DEF_HISTORY_DEPTH;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES = 600;

  localparam logic [1:0] TM_IGNORE = 2'd2;
  localparam logic [1:0] TM_SPARE = 2'd3;
  localparam logic [ppso_pkg::CFG_IDX_W-1:0] REG_NONE_A = 3'd6;
  localparam logic [ppso_pkg::CFG_IDX_W-1:0] REG_NONE_B = 3'd7;

  typedef struct packed {
    logic        op;
    logic [15:0] ticks;
    logic        ign;
  } sensor_beat_t;

  typedef struct packed {
    logic [7:0]  kmh;
    logic [31:0] mileage;
    logic        pin;
  } odo_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ppso_pkg::OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ppso_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppso_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pulse_period_speed_odometer DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and state
  logic [23:0] reg_ppk;
  logic [15:0] reg_min;
  logic [31:0] reg_preset;
  logic        reg_avg;
  logic        reg_jump;
  logic [1:0]  reg_mode;
  logic [1:0]  pulse_run;
  logic [31:0] pulse_backlog;
  logic [31:0] odo_hundredths;
  logic [7:0]  speed_kmh;
  logic [7:0]  speed_prev;
  logic [6:0]  jump_count;
  logic [15:0] period_hist [HIST_N];
  logic [2:0]  hist_ptr;
  logic        div2_phase;

  sensor_beat_t beat_q[$];
  odo_reading_t reading_q[$];

  int beats_offered = 0;
  int beats_taken = 0;
  int outs_seen = 0;
  int bad_count = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic calm = 1'b0;

  int pulses_seen = 0;
  int timeouts_seen = 0;
  int glitches_seen = 0;
  int odo_updates = 0;
  int jump_releases = 0;
  int reg_writes = 0;

  function automatic void reset_model();
    reg_ppk = ppso_pkg::PPK_RESET;
    reg_min = ppso_pkg::MIN_RESET;
    reg_preset = '0;
    reg_avg = 1'b0;
    reg_jump = 1'b0;
    reg_mode = ppso_pkg::TM_NORMAL;
    pulse_run = '0;
    pulse_backlog = '0;
    odo_hundredths = '0;
    speed_kmh = '0;
    speed_prev = '0;
    jump_count = '0;
    for (int i = 0; i < HIST_N; i++) period_hist[i] = '0;
    hist_ptr = '0;
    div2_phase = 1'b0;
  endfunction

  function automatic void apply_reg(logic [ppso_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      ppso_pkg::REG_PPK: reg_ppk = data[23:0];
      ppso_pkg::REG_MIN_INTERVAL: reg_min = data[15:0];
      ppso_pkg::REG_MILEAGE_PRESET: begin
        reg_preset = data;
        odo_hundredths = data;
      end
      ppso_pkg::REG_AVERAGING: reg_avg = data[0];
      ppso_pkg::REG_JUMP_FILTER: reg_jump = data[0];
      ppso_pkg::REG_TEST_MODE: reg_mode = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic void hold_speed(logic [7:0] s);
    speed_kmh = s;
    speed_prev = s;
  endfunction

  // latest period, or trimmed mean of the history when averaging
  function automatic logic [15:0] push_period(logic [15:0] t);
    logic [19:0] total;
    logic [15:0] lo;
    logic [15:0] hi;
    if (!reg_avg) begin
      period_hist[0] = t;
      return t;
    end
    hist_ptr = (hist_ptr + 1 >= HIST_N) ? 3'd0 : hist_ptr + 3'd1;
    period_hist[hist_ptr] = t;
    lo = period_hist[0];
    hi = period_hist[0];
    total = '0;
    for (int i = 0; i < HIST_N; i++) begin
      if (period_hist[i] < lo) lo = period_hist[i];
      if (period_hist[i] > hi) hi = period_hist[i];
      total = total + period_hist[i];
    end
    return 16'((total - lo - hi) / (HIST_N - 2));
  endfunction

  function automatic logic [7:0] kmh_from_period(logic [15:0] basis);
    logic [63:0] den;
    logic [63:0] q;
    if (reg_ppk == 0) return ppso_pkg::SPEED_MAX;
    den = 64'(basis) * 64'(reg_ppk);
    q = (64'(ppso_pkg::SPEED_NUM2) + den) / (2 * den);
    return (q > 64'(ppso_pkg::SPEED_MAX)) ? ppso_pkg::SPEED_MAX : q[7:0];
  endfunction

  function automatic void predict_beat(logic op, logic [15:0] t, logic ign);
    logic first;
    logic [15:0] basis;
    logic [7:0] s;
    odo_reading_t r;
    if (op == ppso_pkg::OP_TIMEOUT) begin
      timeouts_seen++;
      pulse_run = '0;
      hold_speed(8'd0);
      for (int i = 0; i < HIST_N; i++) period_hist[i] = '0;
    end else if (reg_mode == ppso_pkg::TM_DIV2) begin
      div2_phase = ~div2_phase;
    end else if (reg_mode == ppso_pkg::TM_NORMAL) begin
      pulses_seen++;
      first = (pulse_run == 0);
      if (pulse_run < 2) pulse_run = pulse_run + 2'd1;
      pulse_backlog = pulse_backlog + 32'd1;
      if (!first) begin
        if (t < reg_min) begin
          pulse_backlog = pulse_backlog - 32'd1;
          glitches_seen++;
        end else begin
          if (ign && reg_ppk != 0 && pulse_backlog > reg_ppk / ppso_pkg::ODO_RATIO) begin
            odo_hundredths = odo_hundredths +
                             32'((64'(pulse_backlog) * ppso_pkg::ODO_SCALE) / reg_ppk);
            pulse_backlog = '0;
            odo_updates++;
          end
          basis = push_period(t);
          if (basis != 0) begin
            if (!ign) begin
              hold_speed(8'd0);
            end else begin
              s = kmh_from_period(basis);
              if (reg_jump && s > speed_prev) begin
                if (s - speed_prev >= ppso_pkg::JUMP_LIMIT) begin
                  jump_count = jump_count + 7'd1;
                  if (jump_count >= ppso_pkg::JUMP_TRIES) begin
                    jump_count = '0;
                    hold_speed(s);
                    jump_releases++;
                  end
                end else begin
                  jump_count = '0;
                  hold_speed(s);
                end
              end else begin
                hold_speed(s);
              end
            end
          end
        end
      end
    end
    r.kmh = speed_kmh;
    r.mileage = odo_hundredths;
    r.pin = (reg_mode == ppso_pkg::TM_DIV2 && div2_phase == 1'b0);
    reading_q.push_back(r);
  endfunction

  function automatic void note_bad(string field, logic [31:0] want, logic [31:0] got);
    bad_count++;
    if (bad_count <= 10)
      $display("mismatch at cycle %0d on %s: expected %0d, got %0d", cycles, field, want, got);
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && beats_taken != beats_offered) begin
      // beat still waiting for tready
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (beat_q.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap_left <= $urandom_range(0, 3);
    end else begin
      s_tvalid <= 1'b1;
      s_tuser <= beat_q[0].op;
      s_tdata <= {{(IN_W - 17){1'b0}}, beat_q[0].ign, beat_q[0].ticks};
      beats_offered <= beats_offered + 1;
    end
  end

  // receiver, with one long hold-off so the input side backs up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && outs_seen >= 150) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: register writes, accepted input beats, output beats
  always @(posedge clk) begin
    odo_reading_t got;
    odo_reading_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (m_tvalid && m_tready) begin
        got.kmh = m_tdata[7:0];
        got.mileage = m_tdata[39:8];
        got.pin = m_tdata[40];
        outs_seen++;
        if (reading_q.size() == 0) begin
          note_bad("unexpected beat", 32'd0, 32'd1);
        end else begin
          want = reading_q.pop_front();
          if (got.kmh !== want.kmh) note_bad("instant_speed", want.kmh, got.kmh);
          if (got.mileage !== want.mileage)
            note_bad("total_mileage", want.mileage, got.mileage);
          if (got.pin !== want.pin) note_bad("test_output", want.pin, got.pin);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_beat(s_tuser, s_tdata[15:0], s_tdata[16]);
        void'(beat_q.pop_front());
        beats_taken <= beats_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("pulse_period_speed_odometer test failed");
      $finish;
    end
  end

  task automatic queue_beat(input logic op, input logic [15:0] t, input logic ign);
    sensor_beat_t b;
    b.op = op;
    b.ticks = t;
    b.ign = ign;
    beat_q.push_back(b);
  endtask

  task automatic write_reg(input logic [ppso_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (beat_q.size() != 0 || reading_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(input logic [23:0] ppk, input logic [15:0] lim,
                               input logic [31:0] preset, input logic avg,
                               input logic jmp, input logic [1:0] mode);
    settle();
    write_reg(ppso_pkg::REG_PPK, {8'($urandom), ppk});
    write_reg(ppso_pkg::REG_MIN_INTERVAL, {16'($urandom), lim});
    write_reg(ppso_pkg::REG_MILEAGE_PRESET, preset);
    write_reg(ppso_pkg::REG_AVERAGING, {31'($urandom), avg});
    write_reg(ppso_pkg::REG_JUMP_FILTER, {31'($urandom), jmp});
    write_reg(ppso_pkg::REG_TEST_MODE, {30'($urandom), mode});
  endtask

  function automatic logic [15:0] ticks_for_speed(int kmh);
    longint q;
    if (reg_ppk == 0) return 16'($urandom_range(1, 65535));
    q = 72000000 / (longint'(kmh) * longint'(reg_ppk));
    if (q < 1) q = 1;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  // a drive: timeout, then pulses at a drifting speed with glitches,
  // sudden jumps, ignition drops, further timeouts and some raw noise
  task automatic random_trip(input int count);
    int kmh;
    int r;
    int j;
    logic [15:0] base;
    logic [15:0] t;
    kmh = $urandom_range(1, 260);
    queue_beat(ppso_pkg::OP_TIMEOUT, 16'($urandom), 1'b1);
    for (int k = 1; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_beat(ppso_pkg::OP_TIMEOUT, 16'($urandom), 1'($urandom));
      end else if (r < 8) begin
        t = (reg_min == 0) ? 16'd0 : 16'($urandom_range(0, reg_min - 1));
        queue_beat(ppso_pkg::OP_PULSE, t, 1'b1);
      end else if (r < 11) begin
        queue_beat(ppso_pkg::OP_PULSE, 16'($urandom), 1'($urandom));
      end else begin
        if (r < 14) kmh = $urandom_range(1, 300);
        else if (r < 30) kmh = kmh + int'($urandom_range(0, 10)) - 5;
        if (kmh < 1) kmh = 1;
        base = ticks_for_speed(kmh);
        j = int'(base) - int'(base / 16) + int'($urandom_range(0, base / 8));
        if (j < 0) j = 0;
        if (j > 65535) j = 65535;
        queue_beat(ppso_pkg::OP_PULSE, 16'(j), $urandom_range(0, 99) < 96);
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings: first pulse, glitch edges, saturation, ignition off, timeouts
    queue_beat(ppso_pkg::OP_PULSE, 16'hFFFF, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd0, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd38, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd39, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'hFFFF, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b0);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_TIMEOUT, 16'hFFFF, 1'b1);
    queue_beat(ppso_pkg::OP_TIMEOUT, 16'd0, 1'b0);
    queue_beat(ppso_pkg::OP_PULSE, 16'd200, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd200, 1'b1);
    settle();
    // trimmed mean over a mostly empty history gives a zero period
    write_reg(ppso_pkg::REG_AVERAGING, 32'd1);
    queue_beat(ppso_pkg::OP_TIMEOUT, 16'd0, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    settle();
    write_reg(ppso_pkg::REG_PPK, 32'd0);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    settle();
    write_reg(ppso_pkg::REG_PPK, 32'd7200);
    write_reg(ppso_pkg::REG_AVERAGING, 32'd0);
    write_reg(ppso_pkg::REG_JUMP_FILTER, 32'd1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd200, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd40, 1'b1);
    settle();
    write_reg(ppso_pkg::REG_TEST_MODE, 32'(ppso_pkg::TM_DIV2));
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_TIMEOUT, 16'd100, 1'b1);
    settle();
    write_reg(ppso_pkg::REG_TEST_MODE, 32'(TM_IGNORE));
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    queue_beat(ppso_pkg::OP_TIMEOUT, 16'd100, 1'b1);
    settle();
    write_reg(ppso_pkg::REG_TEST_MODE, 32'(TM_SPARE));
    queue_beat(ppso_pkg::OP_PULSE, 16'd100, 1'b1);
    settle();
    write_reg(REG_NONE_A, $urandom);
    write_reg(REG_NONE_B, $urandom);
    write_reg(ppso_pkg::REG_MILEAGE_PRESET, 32'hFFFFFFFF);
    write_reg(ppso_pkg::REG_TEST_MODE, 32'(ppso_pkg::TM_NORMAL));

    load_settings(24'd7200, 16'd39, 32'd0, 1'b0, 1'b0, ppso_pkg::TM_NORMAL);
    random_trip(200);
    load_settings(24'd50, 16'd0, $urandom, 1'b1, 1'b0, ppso_pkg::TM_NORMAL);
    random_trip(200);
    // one km (a hundred hundredths) per pulse step, starting just below the wrap
    load_settings(24'd1, 16'd0, 32'hFFFFF000, 1'b0, 1'b1, ppso_pkg::TM_NORMAL);
    random_trip(150);
    load_settings(24'd7200, 16'hFFFF, $urandom, 1'b0, 1'b0, ppso_pkg::TM_NORMAL);
    queue_beat(ppso_pkg::OP_PULSE, 16'hFFFF, 1'b1);
    queue_beat(ppso_pkg::OP_PULSE, 16'hFFFF, 1'b1);
    random_trip(40);
    load_settings(24'hFFFFFF, 16'd0, $urandom, 1'b1, 1'b1, ppso_pkg::TM_NORMAL);
    random_trip(120);
    repeat (3) begin
      load_settings(24'($urandom_range(1, 20000)), 16'($urandom_range(0, 80)), $urandom,
                    1'($urandom), 1'($urandom), ppso_pkg::TM_NORMAL);
      random_trip(100);
    end
    load_settings(24'd3600, 16'd20, $urandom, 1'b1, 1'b0, ppso_pkg::TM_DIV2);
    random_trip(60);
    load_settings(24'd3600, 16'd20, $urandom, 1'b0, 1'b0, TM_IGNORE);
    random_trip(30);
    load_settings(24'd3600, 16'd20, $urandom, 1'b0, 1'b1, TM_SPARE);
    random_trip(30);
    load_settings(24'd7200, 16'd39, $urandom, 1'b1, 1'b1, ppso_pkg::TM_NORMAL);
    calm = 1'b1;
    random_trip(300);

    settle();
    repeat (300) @(posedge clk);
    $display("covered %0d pulses and %0d timeouts with %0d register writes",
             pulses_seen, timeouts_seen, reg_writes);
    $display("%0d glitches, %0d distance steps, %0d jump-filter releases, %0d beats checked",
             glitches_seen, odo_updates, jump_releases, outs_seen);
    if (bad_count == 0 && reading_q.size() == 0) begin
      $display("pulse_period_speed_odometer test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", bad_count, reading_q.size());
      $display("pulse_period_speed_odometer test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ppso_pkg.sv
hw/rtl/ppso_div.sv
hw/rtl/pulse_period_speed_odometer.sv
hw/rtl/ppso_chk.sv
tb/sv/tb_top.sv
